// ----- hw/rtl/sacfl_pkg.sv -----
// shared types and constants of the set-associative cache tag model
package sacfl_pkg;

	localparam int MAX_SETS   = 256;
	localparam int SET_W      = $clog2(MAX_SETS);
	localparam int MAX_WAYS   = 8;
	localparam int WAY_W      = $clog2(MAX_WAYS);
	localparam int ADDR_BITS  = 48;
	localparam int COUNT_BITS = 32;
	localparam int AGE_W      = 3;
	localparam int AGE_MAX    = 7;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY  = 2'd0,
		CFG_WAYS    = 2'd1,
		CFG_SETBITS = 2'd2,
		CFG_OFFSET  = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		POL_FIFO = 1'b0,
		POL_LRU  = 1'b1
	} policy_t;

	typedef enum logic {
		BK_IDLE,
		BK_LOOK
	} bk_state_t;

	typedef struct packed {
		logic                 func;
		logic [ADDR_BITS-1:0] address;
	} in_t;

	typedef struct packed {
		logic                  hit;
		logic                  memory_read;
		logic                  memory_write;
		logic [COUNT_BITS-1:0] hit_total;
		logic [COUNT_BITS-1:0] miss_total;
		logic [COUNT_BITS-1:0] read_total;
		logic [COUNT_BITS-1:0] write_total;
	} out_t;

	typedef struct packed {
		logic                 func;
		logic [SET_W-1:0]     set_idx;
		logic [ADDR_BITS-1:0] tag;
	} req_t;

	typedef struct packed {
		logic       policy;
		logic [3:0] ways;
		logic [3:0] set_bits;
		logic [4:0] offset_bits;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic [ADDR_BITS-1:0] tag;
		logic [AGE_W-1:0]     age;
	} way_t;

	typedef way_t [MAX_WAYS-1:0] row_t;

endpackage

// ----- hw/rtl/sacfl_front.sv -----
// front stage: splits the address into set and tag
module sacfl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  sacfl_pkg::cfg_t   cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  sacfl_pkg::in_t    in_data,
	output logic              push,
	output sacfl_pkg::req_t   push_data,
	input  logic              q_full
);
	import sacfl_pkg::*;

	logic                 valid_s1;
	req_t                 req_s1;
	logic [3:0]           sbits;
	logic [5:0]           tag_shift;
	logic [ADDR_BITS-1:0] addr_sh;
	logic [SET_W:0]       set_mask;
	logic                 load;

	always_comb begin
		sbits     = (cfg.set_bits > 4'(SET_W)) ? 4'(SET_W) : cfg.set_bits;
		addr_sh   = in_data.address >> cfg.offset_bits;
		set_mask  = (SET_W+1)'(((SET_W+1)'(1) << sbits) - (SET_W+1)'(1));
		tag_shift = 6'(cfg.offset_bits) + 6'(sbits);
	end

	assign push      = valid_s1 && !q_full;
	assign push_data = req_s1;
	assign in_stall  = valid_s1 && q_full;
	assign load      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_s1.func    <= in_data.func;
			req_s1.set_idx <= addr_sh[SET_W-1:0] & set_mask[SET_W-1:0];
			req_s1.tag     <= in_data.address >> tag_shift;
		end
	end

endmodule

// ----- hw/rtl/sacfl_queue.sv -----
// short request queue between front and back
module sacfl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sacfl_pkg::req_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output sacfl_pkg::req_t head
);
	import sacfl_pkg::*;

	req_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = count_q == (QPTR_W+1)'(QDEPTH);
	assign empty = count_q == '0;
	assign head  = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= push_data;
	end

endmodule

// ----- hw/rtl/sacfl_back.sv -----
// back end: set read, way compare, replacement and counters
module sacfl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sacfl_pkg::cfg_t cfg,
	input  logic            q_empty,
	input  sacfl_pkg::req_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output sacfl_pkg::out_t out_data
);
	import sacfl_pkg::*;

	row_t                  row_mem [MAX_SETS];
	logic [MAX_SETS-1:0]   row_vld_q;
	row_t                  rd_row_q;
	logic                  rd_rowv_q;
	req_t                  req_q;
	bk_state_t             state_q, state_d;
	logic                  out_valid_q;
	out_t                  out_q;
	logic [COUNT_BITS-1:0] hits_q, misses_q, reads_q, writes_q;

	logic                  finish;
	logic [3:0]            ways;
	logic [MAX_WAYS-1:0]   vld;
	logic                  hit, have_empty, any, do_upd;
	logic [WAY_W-1:0]      found, empty_w, victim, tgt;
	logic [AGE_W-1:0]      oldest;
	logic [AGE_W:0]        limit;
	row_t                  new_row;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = BK_LOOK;
				end
			end
			BK_LOOK: begin
				if (!out_valid_q || !out_stall) begin
					finish  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// way compare, empty search and victim search
	always_comb begin
		ways       = (cfg.ways == 4'd0) ? 4'd1 :
		             (cfg.ways > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : cfg.ways;
		hit        = 1'b0;
		have_empty = 1'b0;
		any        = 1'b0;
		found      = '0;
		empty_w    = '0;
		victim     = '0;
		oldest     = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			vld[w] = rd_rowv_q && rd_row_q[w].valid && (4'(w) < ways);
			if (vld[w] && !hit && rd_row_q[w].tag == req_q.tag) begin
				hit   = 1'b1;
				found = WAY_W'(w);
			end
			if (!vld[w] && (4'(w) < ways) && !have_empty) begin
				have_empty = 1'b1;
				empty_w    = WAY_W'(w);
			end
			if (vld[w] && (!any || rd_row_q[w].age > oldest)) begin
				any    = 1'b1;
				oldest = rd_row_q[w].age;
				victim = WAY_W'(w);
			end
		end
	end

	// row update
	always_comb begin
		do_upd = !hit || (cfg.policy == POL_LRU);
		if (hit) begin
			tgt   = found;
			limit = {1'b0, rd_row_q[found].age};
		end else if (have_empty) begin
			tgt   = empty_w;
			limit = (AGE_W+1)'(AGE_MAX + 1);
		end else begin
			tgt   = victim;
			limit = {1'b0, oldest};
		end
		new_row = rd_row_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (!rd_rowv_q) new_row[w].valid = 1'b0;
			if (do_upd) begin
				if (WAY_W'(w) == tgt) begin
					new_row[w].age = '0;
					if (!hit) begin
						new_row[w].valid = 1'b1;
						new_row[w].tag   = req_q.tag;
					end
				end else if (vld[w] && ({1'b0, rd_row_q[w].age} < limit)
				             && (rd_row_q[w].age < AGE_W'(AGE_MAX))) begin
					new_row[w].age = rd_row_q[w].age + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			row_vld_q   <= '0;
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
			reads_q     <= '0;
			writes_q    <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				row_vld_q[req_q.set_idx] <= 1'b1;
				out_valid_q <= 1'b1;
				hits_q      <= hits_q + COUNT_BITS'(hit);
				misses_q    <= misses_q + COUNT_BITS'(!hit);
				reads_q     <= reads_q + COUNT_BITS'(!hit);
				writes_q    <= writes_q + COUNT_BITS'(req_q.func);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_row_q  <= row_mem[head.set_idx];
			rd_rowv_q <= row_vld_q[head.set_idx];
			req_q     <= head;
		end
		if (finish) begin
			row_mem[req_q.set_idx] <= new_row;
			out_q.hit          <= hit;
			out_q.memory_read  <= !hit;
			out_q.memory_write <= req_q.func;
			out_q.hit_total    <= hits_q + COUNT_BITS'(hit);
			out_q.miss_total   <= misses_q + COUNT_BITS'(!hit);
			out_q.read_total   <= reads_q + COUNT_BITS'(!hit);
			out_q.write_total  <= writes_q + COUNT_BITS'(req_q.func);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/set_assoc_cache_fifo_lru.sv -----
// top level of the set-associative cache tag model with fifo or lru replacement
// Every access transfer gives one result transfer with hit, memory read and memory write
// flags and the four wrapping 32-bit totals after that access. A front stage splits
// the address into set index and tag (one register stage), a two-entry queue decouples
// it from the back end, which handles one access at a time: in BK_IDLE it pops the
// request and reads the whole set row (all eight ways of tag, valid and age) from the
// set memory into a register; in BK_LOOK it compares the ways, picks the empty or
// victim way, writes the row back and loads the output register, and it waits there
// while a stalled result is held. It takes no new access until the last one is done,
// set by that read-then-write of the set memory.
// Each set row carries a valid flip-flop cleared at reset, so no clearing pass is needed.
// Configuration registers (0 policy, 1 ways, 2 set index bits, 3 offset bits) must be
// written by the user only while no access is in flight; the block does not enforce it.
module set_assoc_cache_fifo_lru (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  sacfl_pkg::in_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output sacfl_pkg::out_t                      out_data,
	input  logic                                 cfg_we,
	input  logic [sacfl_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [sacfl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sacfl_pkg::*;

	cfg_t cfg_q;
	logic push, q_full, q_empty, pop;
	req_t push_data, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy      <= POL_FIFO;
			cfg_q.ways        <= 4'd1;
			cfg_q.set_bits    <= '0;
			cfg_q.offset_bits <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_POLICY:  cfg_q.policy      <= cfg_data[0];
				CFG_WAYS:    cfg_q.ways        <= cfg_data[3:0];
				CFG_SETBITS: cfg_q.set_bits    <= cfg_data[3:0];
				CFG_OFFSET:  cfg_q.offset_bits <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// address split
	sacfl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// decoupling queue
	sacfl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	// lookup, replacement and totals
	sacfl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/sacfl_checker.sv -----
// port-level checks of the cache tag model
module sacfl_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input sacfl_pkg::out_t out_data
);
	import sacfl_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// a fetch happens exactly on a miss
	a_read_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.memory_read != out_data.hit)
		else $error("memory read flag disagrees with hit");

	// every miss is one fetch, so the two totals move together
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.miss_total == out_data.read_total)
		else $error("miss and read totals differ");

endmodule

bind set_assoc_cache_fifo_lru sacfl_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
